/* src/fpa_pkg.sv */
// Shared types, constants and codes for the tabulated pair force accumulator.
// No dependencies; every other file except fpa_ram refers to it by scoped names.
package fpa_pkg;

  localparam int PARTICLE_COUNT_DEF = 1024;
  localparam int TABLE_DEPTH_DEF    = 1024;

  localparam int IDX_W     = 10;
  localparam int COORD_W   = 32;
  localparam int ACC_W     = 48;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int ROWS_W    = 11;
  localparam int DELTA_W   = 33;
  localparam int CNT_W     = 6;

  localparam int SQRT_STEPS = 34;
  localparam int DIV_STEPS  = 51;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] REQ_PAIR   = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_ENABLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THREE_DIMS   = 2'd3;

  localparam logic [CFG_W-1:0]  INV_SPACING_RST = 32'd65536;
  localparam logic [ROWS_W-1:0] ROWS_RST        = 11'd1024;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         first_index;
    logic [IDX_W-1:0]         second_index;
    logic signed [COORD_W-1:0] pos_i_x;
    logic signed [COORD_W-1:0] pos_i_y;
    logic signed [COORD_W-1:0] pos_i_z;
    logic signed [COORD_W-1:0] pos_j_x;
    logic signed [COORD_W-1:0] pos_j_y;
    logic signed [COORD_W-1:0] pos_j_z;
    logic signed [COORD_W-1:0] coef_const;
    logic signed [COORD_W-1:0] coef_linear;
    logic signed [COORD_W-1:0] coef_square;
  } fpa_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]        particle_id;
    logic signed [ACC_W-1:0] total_x;
    logic signed [ACC_W-1:0] total_y;
    logic signed [ACC_W-1:0] total_z;
  } fpa_out_t;

  typedef struct packed {
    logic [CFG_W-1:0]  inv_spacing;
    logic [ROWS_W-1:0] rows_in_use;
    logic              force_enable;
    logic              three_dims;
  } fpa_cfg_t;

  typedef enum logic [1:0] {KIND_PAIR, KIND_READ, KIND_LOAD} fpa_kind_t;

  typedef struct packed {
    fpa_kind_t                 kind;
    logic [IDX_W-1:0]          first_index;
    logic [IDX_W-1:0]          second_index;
    logic                      idx_ok;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] dz;
    logic signed [COORD_W-1:0] c0;
    logic signed [COORD_W-1:0] c1;
    logic signed [COORD_W-1:0] c2;
  } fpa_cmd_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_RD_DATA, ST_SQ, ST_SQRT, ST_POS, ST_TBL,
    ST_POLY1, ST_POLY2, ST_POLY3, ST_POLY4, ST_DIV, ST_COMP,
    ST_RD_I, ST_WR_I, ST_RD_J, ST_WR_J
  } fpa_state_t;

endpackage

/* src/fpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/fpa_front.sv */
// Front end: accepts input words, drops ones with no effect, forms commands.
// Depends on fpa_pkg.
module fpa_front #(
  parameter int PARTICLE_COUNT = fpa_pkg::PARTICLE_COUNT_DEF,
  parameter int TABLE_DEPTH    = fpa_pkg::TABLE_DEPTH_DEF
) (
  input  logic              in_valid,
  output logic              in_ready,
  input  fpa_pkg::fpa_in_t  in_data,
  input  fpa_pkg::fpa_cfg_t cfg,
  input  logic              clearing,
  output logic              push_valid,
  input  logic              push_ready,
  output fpa_pkg::fpa_cmd_t push_data
);

  logic i_ok, j_ok, row_ok, keep;
  fpa_pkg::fpa_kind_t kind;

  assign i_ok   = 32'(in_data.first_index) < 32'(PARTICLE_COUNT);
  assign j_ok   = 32'(in_data.second_index) < 32'(PARTICLE_COUNT);
  assign row_ok = 32'(in_data.first_index) < 32'(TABLE_DEPTH);

  always_comb begin
    keep = 1'b0;
    kind = fpa_pkg::KIND_PAIR;
    case (in_data.req_type)
      fpa_pkg::REQ_PAIR: begin
        keep = i_ok && j_ok && cfg.force_enable;
        kind = fpa_pkg::KIND_PAIR;
      end
      fpa_pkg::REQ_READ: begin
        keep = 1'b1;
        kind = fpa_pkg::KIND_READ;
      end
      fpa_pkg::REQ_LOAD: begin
        keep = row_ok;
        kind = fpa_pkg::KIND_LOAD;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready   = push_ready && !clearing;
  assign push_valid = in_valid && in_ready && keep;

  always_comb begin
    push_data.kind         = kind;
    push_data.first_index  = in_data.first_index;
    push_data.second_index = in_data.second_index;
    push_data.idx_ok       = i_ok;
    push_data.dx = {in_data.pos_j_x[31], in_data.pos_j_x} -
                   {in_data.pos_i_x[31], in_data.pos_i_x};
    push_data.dy = {in_data.pos_j_y[31], in_data.pos_j_y} -
                   {in_data.pos_i_y[31], in_data.pos_i_y};
    // 2-D mode: z delta forced to zero, so z components come out zero
    push_data.dz = cfg.three_dims ?
                   {in_data.pos_j_z[31], in_data.pos_j_z} -
                   {in_data.pos_i_z[31], in_data.pos_i_z} : '0;
    push_data.c0 = in_data.coef_const;
    push_data.c1 = in_data.coef_linear;
    push_data.c2 = in_data.coef_square;
  end

endmodule

/* src/fpa_queue.sv */
// Short command queue between front end and execution engine.
// Depends on fpa_pkg.
module fpa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  fpa_pkg::fpa_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop,
  output fpa_pkg::fpa_cmd_t pop_data
);

  fpa_pkg::fpa_cmd_t               mem_r [fpa_pkg::Q_DEPTH];
  logic [fpa_pkg::Q_AW-1:0]        wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [fpa_pkg::Q_CW-1:0]        count_r, count_nxt;
  logic                            do_push, do_pop;

  assign push_ready = count_r != fpa_pkg::Q_CW'(fpa_pkg::Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == fpa_pkg::Q_AW'(fpa_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == fpa_pkg::Q_AW'(fpa_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* src/fpa_back.sv */
// Execution engine: accumulator clear sweep, table loads, reads (which clear the entry), and the pair
// force sequence (squares, bit-serial sqrt, table lookup, poly, divide, scale).
// Depends on fpa_pkg and fpa_ram.
module fpa_back #(
  parameter int PARTICLE_COUNT = fpa_pkg::PARTICLE_COUNT_DEF,
  parameter int TABLE_DEPTH    = fpa_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fpa_pkg::fpa_cfg_t cfg,
  input  logic              q_valid,
  input  fpa_pkg::fpa_cmd_t q_data,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_ready,
  output fpa_pkg::fpa_out_t out_data
);

  localparam int AW = $clog2(PARTICLE_COUNT);
  localparam int TW = $clog2(TABLE_DEPTH);
  localparam int AC = fpa_pkg::ACC_W;

  function automatic logic [AC-1:0] sat_add(input logic [AC-1:0] a,
                                            input logic [AC-1:0] b,
                                            input logic sub);
    logic [AC:0] sa, sb, s;
    sa = {a[AC-1], a};
    sb = sub ? -{b[AC-1], b} : {b[AC-1], b};
    s  = sa + sb;
    if (s[AC] != s[AC-1]) begin
      sat_add = s[AC] ? {1'b1, {(AC-1){1'b0}}} : {1'b0, {(AC-1){1'b1}}};
    end else begin
      sat_add = s[AC-1:0];
    end
  endfunction

  fpa_pkg::fpa_state_t state_r, state_nxt;
  fpa_pkg::fpa_cmd_t   cmd_r, cmd_nxt;
  logic [fpa_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [67:0]         rad_r, rad_nxt;
  logic [36:0]         rem_r, rem_nxt;
  logic [33:0]         root_r, root_nxt;
  logic [TW-1:0]       kk_r, kk_nxt;
  logic [16:0]         frac_r, frac_nxt;
  logic signed [31:0]  c0_r, c0_nxt, c1_r, c1_nxt;
  logic signed [68:0]  prod_r, prod_nxt;
  logic signed [33:0]  inner_r, inner_nxt;
  logic                fneg_r, fneg_nxt;
  logic [50:0]         num_r, num_nxt;
  logic [34:0]         drem_r, drem_nxt;
  logic [84:0]         cprod_r, cprod_nxt;
  logic signed [AC-1:0] comp_r [3];
  logic signed [AC-1:0] comp_nxt [3];
  logic                out_valid_r, out_valid_nxt;
  fpa_pkg::fpa_out_t   out_data_r, out_data_nxt;

  // datapath helpers
  logic [1:0]          axis;
  logic signed [32:0]  d_sel;
  logic [32:0]         d_mag;
  logic signed [32:0]  c2_ext;
  logic [32:0]         c2_mag;
  logic [33:0]         inner_mag;
  logic [33:0]         mul_a, mul_b;
  logic [67:0]         mul_p;
  logic signed [68:0]  prod_pos, prod_sh;
  logic [31:0]         rows_c, max_row;
  logic [33:0]         pos_ip, kk_full;
  logic                beyond;
  logic [36:0]         sq_sh, sq_trial;
  logic [35:0]         dv_sh;
  logic signed [34:0]  f_v;
  logic [34:0]         f_mag;
  logic [84:0]         tot;
  logic [AC-1:0]       m48;
  logic [31:0]         i32, j32;
  logic [AW-1:0]       i_addr, j_addr;

  // memory ports
  logic [2:0]          acc_we;
  logic [AW-1:0]       acc_waddr, acc_raddr;
  logic [AC-1:0]       acc_wdata [3];
  logic [AC-1:0]       acc_rdata [3];
  logic                tbl_we;
  logic [TW-1:0]       tbl_waddr;
  logic [31:0]         tbl_wdata [3];
  logic [31:0]         tbl_rdata [3];

  assign i32    = 32'(cmd_r.first_index);
  assign j32    = 32'(cmd_r.second_index);
  assign i_addr = i32[AW-1:0];
  assign j_addr = j32[AW-1:0];

  assign axis = (state_r == fpa_pkg::ST_COMP) ? cnt_r[2:1] : cnt_r[1:0];

  always_comb begin
    case (axis)
      2'd0:    d_sel = cmd_r.dx;
      2'd1:    d_sel = cmd_r.dy;
      default: d_sel = cmd_r.dz;
    endcase
  end

  assign d_mag     = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
  assign c2_ext    = {tbl_rdata[2][31], tbl_rdata[2]};
  assign c2_mag    = c2_ext[32] ? 33'(-c2_ext) : 33'(c2_ext);
  assign inner_mag = inner_r[33] ? 34'(-inner_r) : 34'(inner_r);

  // one shared multiplier, operands picked by sequencer step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      fpa_pkg::ST_SQ: begin
        mul_a = {1'b0, d_mag};
        mul_b = {1'b0, d_mag};
      end
      fpa_pkg::ST_POS: begin
        mul_a = root_r;
        mul_b = {2'b0, cfg.inv_spacing};
      end
      fpa_pkg::ST_POLY1: begin
        mul_a = {17'b0, frac_r};
        mul_b = {1'b0, c2_mag};
      end
      fpa_pkg::ST_POLY3: begin
        mul_a = {17'b0, frac_r};
        mul_b = inner_mag;
      end
      fpa_pkg::ST_COMP: begin
        mul_a = {1'b0, d_mag};
        mul_b = cnt_r[0] ? {9'b0, num_r[50:26]} : {8'b0, num_r[25:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = 68'(mul_a) * 68'(mul_b);
  assign prod_pos = $signed({1'b0, mul_p});
  assign prod_sh  = prod_r >>> 16;

  // row position and clamp
  always_comb begin
    rows_c = 32'(cfg.rows_in_use);
    if (rows_c < 32'd2) begin
      rows_c = 32'd2;
    end
    if (rows_c > 32'(TABLE_DEPTH)) begin
      rows_c = 32'(TABLE_DEPTH);
    end
    max_row = rows_c - 32'd2;
  end

  assign pos_ip  = mul_p[65:32];
  assign beyond  = pos_ip > {2'b0, max_row};
  assign kk_full = beyond ? {2'b0, max_row} : pos_ip;

  assign sq_sh    = {rem_r[34:0], rad_r[67:66]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign dv_sh    = {drem_r, num_r[50]};

  assign f_v   = $signed({{3{c0_r[31]}}, c0_r}) + prod_sh[34:0];
  assign f_mag = f_v[34] ? 35'(-f_v) : 35'(f_v);

  assign tot = cprod_r + {mul_p[58:0], 26'b0};
  assign m48 = {1'b0, (|tot[84:63]) ? {(AC-1){1'b1}} : tot[62:16]};

  assign tbl_waddr    = i32[TW-1:0];
  assign tbl_wdata[0] = cmd_r.c0;
  assign tbl_wdata[1] = cmd_r.c1;
  assign tbl_wdata[2] = cmd_r.c2;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    kk_nxt        = kk_r;
    frac_nxt      = frac_r;
    c0_nxt        = c0_r;
    c1_nxt        = c1_r;
    prod_nxt      = prod_r;
    inner_nxt     = inner_r;
    fneg_nxt      = fneg_r;
    num_nxt       = num_r;
    drem_nxt      = drem_r;
    cprod_nxt     = cprod_r;
    comp_nxt      = comp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    acc_we        = 3'b000;
    acc_waddr     = i_addr;
    acc_raddr     = i_addr;
    acc_wdata[0]  = '0;
    acc_wdata[1]  = '0;
    acc_wdata[2]  = '0;
    tbl_we        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      fpa_pkg::ST_CLEAR: begin
        acc_we    = 3'b111;
        acc_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(PARTICLE_COUNT - 1)) begin
          state_nxt = fpa_pkg::ST_IDLE;
        end
      end
      fpa_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          state_nxt = fpa_pkg::ST_EXEC;
        end
      end
      fpa_pkg::ST_EXEC: begin
        case (cmd_r.kind)
          fpa_pkg::KIND_LOAD: begin
            tbl_we    = 1'b1;
            state_nxt = fpa_pkg::ST_IDLE;
          end
          fpa_pkg::KIND_READ: begin
            // hold until the result register is free
            if (!out_valid_r) begin
              state_nxt = fpa_pkg::ST_RD_DATA;
            end
          end
          default: begin
            rad_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = fpa_pkg::ST_SQ;
          end
        endcase
      end
      fpa_pkg::ST_RD_DATA: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.particle_id = cmd_r.first_index;
        out_data_nxt.total_x     = cmd_r.idx_ok ? acc_rdata[0] : '0;
        out_data_nxt.total_y     = cmd_r.idx_ok ? acc_rdata[1] : '0;
        out_data_nxt.total_z     = cmd_r.idx_ok ? acc_rdata[2] : '0;
        acc_we                   = cmd_r.idx_ok ? 3'b111 : 3'b000;
        state_nxt                = fpa_pkg::ST_IDLE;
      end
      fpa_pkg::ST_SQ: begin
        rad_nxt = rad_r + mul_p;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == fpa_pkg::CNT_W'(2)) begin
          cnt_nxt   = '0;
          rem_nxt   = '0;
          root_nxt  = '0;
          state_nxt = fpa_pkg::ST_SQRT;
        end
      end
      fpa_pkg::ST_SQRT: begin
        rad_nxt = {rad_r[65:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          rem_nxt  = sq_sh - sq_trial;
          root_nxt = {root_r[32:0], 1'b1};
        end else begin
          rem_nxt  = sq_sh;
          root_nxt = {root_r[32:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == fpa_pkg::CNT_W'(fpa_pkg::SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          // zero distance: no force, nothing changes
          state_nxt = (root_nxt == '0) ? fpa_pkg::ST_IDLE : fpa_pkg::ST_POS;
        end
      end
      fpa_pkg::ST_POS: begin
        kk_nxt    = kk_full[TW-1:0];
        frac_nxt  = beyond ? 17'h10000 : {1'b0, mul_p[31:16]};
        state_nxt = fpa_pkg::ST_TBL;
      end
      fpa_pkg::ST_TBL: begin
        state_nxt = fpa_pkg::ST_POLY1;
      end
      fpa_pkg::ST_POLY1: begin
        c0_nxt    = tbl_rdata[0];
        c1_nxt    = tbl_rdata[1];
        prod_nxt  = c2_ext[32] ? -prod_pos : prod_pos;
        state_nxt = fpa_pkg::ST_POLY2;
      end
      fpa_pkg::ST_POLY2: begin
        inner_nxt = $signed({{2{c1_r[31]}}, c1_r}) + prod_sh[33:0];
        state_nxt = fpa_pkg::ST_POLY3;
      end
      fpa_pkg::ST_POLY3: begin
        prod_nxt  = inner_r[33] ? -prod_pos : prod_pos;
        state_nxt = fpa_pkg::ST_POLY4;
      end
      fpa_pkg::ST_POLY4: begin
        fneg_nxt  = f_v[34];
        num_nxt   = {f_mag, 16'b0};
        drem_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = fpa_pkg::ST_DIV;
      end
      fpa_pkg::ST_DIV: begin
        // restoring divide, quotient shifts in behind the numerator
        if (dv_sh >= {2'b0, root_r}) begin
          drem_nxt = 35'(dv_sh - {2'b0, root_r});
          num_nxt  = {num_r[49:0], 1'b1};
        end else begin
          drem_nxt = dv_sh[34:0];
          num_nxt  = {num_r[49:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == fpa_pkg::CNT_W'(fpa_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = fpa_pkg::ST_COMP;
        end
      end
      fpa_pkg::ST_COMP: begin
        // even step: low partial product, odd step: high part and finish axis
        if (!cnt_r[0]) begin
          cprod_nxt = {17'b0, mul_p};
        end else begin
          comp_nxt[axis] = (d_sel[32] ^ fneg_r) ? -$signed(m48) : $signed(m48);
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == fpa_pkg::CNT_W'(5)) begin
          cnt_nxt   = '0;
          state_nxt = fpa_pkg::ST_RD_I;
        end
      end
      fpa_pkg::ST_RD_I: begin
        acc_raddr = i_addr;
        state_nxt = fpa_pkg::ST_WR_I;
      end
      fpa_pkg::ST_WR_I: begin
        acc_we       = {cfg.three_dims, 2'b11};
        acc_waddr    = i_addr;
        acc_wdata[0] = sat_add(acc_rdata[0], comp_r[0], 1'b0);
        acc_wdata[1] = sat_add(acc_rdata[1], comp_r[1], 1'b0);
        acc_wdata[2] = sat_add(acc_rdata[2], comp_r[2], 1'b0);
        state_nxt    = fpa_pkg::ST_RD_J;
      end
      fpa_pkg::ST_RD_J: begin
        acc_raddr = j_addr;
        state_nxt = fpa_pkg::ST_WR_J;
      end
      fpa_pkg::ST_WR_J: begin
        acc_we       = {cfg.three_dims, 2'b11};
        acc_waddr    = j_addr;
        acc_wdata[0] = sat_add(acc_rdata[0], comp_r[0], 1'b1);
        acc_wdata[1] = sat_add(acc_rdata[1], comp_r[1], 1'b1);
        acc_wdata[2] = sat_add(acc_rdata[2], comp_r[2], 1'b1);
        state_nxt    = fpa_pkg::ST_IDLE;
      end
      default: state_nxt = fpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpa_pkg::ST_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rad_r      <= rad_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    kk_r       <= kk_nxt;
    frac_r     <= frac_nxt;
    c0_r       <= c0_nxt;
    c1_r       <= c1_nxt;
    prod_r     <= prod_nxt;
    inner_r    <= inner_nxt;
    fneg_r     <= fneg_nxt;
    num_r      <= num_nxt;
    drem_r     <= drem_nxt;
    cprod_r    <= cprod_nxt;
    comp_r     <= comp_nxt;
    out_data_r <= out_data_nxt;
  end

  assign clearing  = state_r == fpa_pkg::ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar g = 0; g < 3; g++) begin : g_acc
    fpa_ram #(.WIDTH(AC), .DEPTH(PARTICLE_COUNT)) u_acc (
      .clk   (clk),
      .we    (acc_we[g]),
      .waddr (acc_waddr),
      .wdata (acc_wdata[g]),
      .raddr (acc_raddr),
      .rdata (acc_rdata[g])
    );
    fpa_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tbl (
      .clk   (clk),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata[g]),
      .raddr (kk_r),
      .rdata (tbl_rdata[g])
    );
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpa_pkg::ST_RD_DATA) |-> !out_valid_r)
    else $error("read result would overwrite a pending word");

  a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (cmd_r.kind == fpa_pkg::KIND_LOAD))
    else $error("table written outside a load command");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpa_pkg::ST_DIV) |-> (root_r != '0))
    else $error("divide by zero distance");

  a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpa_pkg::ST_SQRT && cnt_r == '0) |-> (rem_r == '0 && root_r == '0))
    else $error("sqrt started with stale state");

endmodule

/* src/tabulated_pair_force_accumulator_core.sv */
// Tabulated pair force accumulator, top level. A pair goes through 3 squares, 34 sqrt
// steps, 51 divide steps, 6 partial products, poly and accumulator updates. The engine
// runs one command at a time, so pair throughput is set by the bit-serial sqrt and
// divider; a 2-deep queue keeps input flowing meanwhile. After reset the accumulators
// are zeroed by a sweep over all PARTICLE_COUNT entries, during which in_ready is low.
module tabulated_pair_force_accumulator_core #(
  parameter int PARTICLE_COUNT = fpa_pkg::PARTICLE_COUNT_DEF,
  parameter int TABLE_DEPTH    = fpa_pkg::TABLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fpa_pkg::fpa_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fpa_pkg::fpa_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fpa_pkg::CFG_W-1:0]       cfg_wdata
);

  fpa_pkg::fpa_cfg_t cfg_r, cfg_nxt;
  fpa_pkg::fpa_cmd_t push_data, pop_data;
  logic push_valid, push_ready, pop_valid, pop, clearing;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        fpa_pkg::CFG_INV_SPACING:  cfg_nxt.inv_spacing  = cfg_wdata;
        fpa_pkg::CFG_ROWS_IN_USE:  cfg_nxt.rows_in_use  = cfg_wdata[fpa_pkg::ROWS_W-1:0];
        fpa_pkg::CFG_FORCE_ENABLE: cfg_nxt.force_enable = cfg_wdata[0];
        fpa_pkg::CFG_THREE_DIMS:   cfg_nxt.three_dims   = cfg_wdata[0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inv_spacing  <= fpa_pkg::INV_SPACING_RST;
      cfg_r.rows_in_use  <= fpa_pkg::ROWS_RST;
      cfg_r.force_enable <= 1'b1;
      cfg_r.three_dims   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fpa_front #(.PARTICLE_COUNT(PARTICLE_COUNT), .TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  fpa_back #(.PARTICLE_COUNT(PARTICLE_COUNT), .TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (pop_valid),
    .q_data    (pop_data),
    .q_pop     (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
